// ===== hw/rtl/pss_pkg.sv =====
package pss_pkg;

    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int DUE_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [DUE_W-1:0] DUE_MAX = '1;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_ADD,
        OP_NEXT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [DUE_W-1:0]    due;
    } entry_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        op_t    op;
        entry_t ent;
    } cmd_t;

endpackage

// ===== hw/rtl/pss_cell.sv =====
module pss_cell #(
    parameter int SEQ_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head,
    input  pss_pkg::cmd_t     cmd,
    input  logic [SEQ_W-1:0]  cmd_seq,
    input  pss_pkg::entry_t   left_entry,
    input  logic [SEQ_W-1:0]  left_seq,
    input  logic              left_valid,
    input  logic              left_less,
    input  pss_pkg::entry_t   right_entry,
    input  logic [SEQ_W-1:0]  right_seq,
    input  logic              right_less,
    output pss_pkg::entry_t   entry_o,
    output logic [SEQ_W-1:0]  seq_o,
    output logic              valid_o,
    output logic              less_o
);
    import pss_pkg::*;

    entry_t           entry_reg, entry_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             valid_reg, valid_next;
    logic             less;

    // key order: due time, then id, then insertion order; keys never tie
    assign less = valid_reg &&
        ({entry_reg.due, entry_reg.id, seq_reg} < {cmd.ent.due, cmd.ent.id, cmd_seq});

    always_comb begin
        entry_next = entry_reg;
        seq_next   = seq_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_ADD: begin
                if (!less) begin
                    if (left_less) begin
                        entry_next = cmd.ent;
                        seq_next   = cmd_seq;
                        valid_next = 1'b1;
                    end else begin
                        entry_next = left_entry;
                        seq_next   = left_seq;
                        valid_next = left_valid;
                    end
                end
            end
            OP_NEXT: begin
                // head leaves, smaller entries move toward the head, updated one drops in
                if (right_less) begin
                    entry_next = right_entry;
                    seq_next   = right_seq;
                    valid_next = 1'b1;
                end else if (less || head) begin
                    entry_next = cmd.ent;
                    seq_next   = cmd_seq;
                    valid_next = 1'b1;
                end
            end
            OP_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
        seq_reg   <= seq_next;
    end

    assign entry_o = entry_reg;
    assign seq_o   = seq_reg;
    assign valid_o = valid_reg;
    assign less_o  = less;

endmodule

// ===== hw/rtl/periodic_send_scheduler.sv =====
// Periodic send scheduler: keeps up to ENTRIES users, each with an id, a
// period and a due time that starts at the period, in a sorted chain of cells.
// Input channel (s_valid/s_ready): s_func selects add, next or clear; add uses
// s_user_id and s_send_period. Result channel (m_valid/m_ready): m_status and
// m_chosen_id, one result for every request.
// A next request serves the user with the smallest due time (ties by smaller
// id, then by earliest add) and pushes its due time on by its period,
// saturating at the largest due time.
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver takes results. Every cell
// compares its key against the broadcast entry and picks its own, its
// neighbor's or the new value in that same cycle.
// When the receiver stalls, the result register holds and s_ready drops until
// the result is taken; no request is lost.
// Reset empties the set: every cell valid bit and the user count clear at
// once; requests may follow in the next cycle.
module periodic_send_scheduler #(
    parameter int ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pss_pkg::FUNC_W-1:0]      s_func,
    input  logic [pss_pkg::ID_W-1:0]        s_user_id,
    input  logic [pss_pkg::PERIOD_W-1:0]    s_send_period,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pss_pkg::STATUS_W-1:0]    m_status,
    output logic [pss_pkg::ID_W-1:0]        m_chosen_id
);
    import pss_pkg::*;

    localparam int SEQ_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     chosen_reg, chosen_next;

    logic                s_fire;
    logic                full, empty;
    logic [DUE_W:0]      due_sum;
    logic [DUE_W-1:0]    due_upd;
    cmd_t                cmd;
    logic [SEQ_W-1:0]    cmd_seq;

    entry_t              cell_entry [ENTRIES];
    logic [SEQ_W-1:0]    cell_seq   [ENTRIES];
    logic                cell_valid [ENTRIES];
    logic                cell_less  [ENTRIES];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(ENTRIES));
    assign empty   = (count_reg == '0);

    // head entry advanced by its period, saturating
    assign due_sum = {1'b0, cell_entry[0].due} + {{(DUE_W + 1 - PERIOD_W){1'b0}},
                                                  cell_entry[0].period};
    assign due_upd = due_sum[DUE_W] ? DUE_MAX : due_sum[DUE_W-1:0];

    always_comb begin
        cmd.op      = OP_IDLE;
        cmd.ent     = cell_entry[0];
        cmd_seq     = cell_seq[0];
        count_next  = count_reg;
        status_next = STATUS_OK;
        chosen_next = '0;
        if (s_func == FUNC_ADD) begin
            cmd.ent.id     = s_user_id;
            cmd.ent.period = s_send_period;
            cmd.ent.due    = {{(DUE_W - PERIOD_W){1'b0}}, s_send_period};
            cmd_seq        = count_reg[SEQ_W-1:0];
            if (full) begin
                status_next = STATUS_FULL;
            end else if (s_fire) begin
                cmd.op     = OP_ADD;
                count_next = count_reg + CNT_W'(1);
            end
        end else if (s_func == FUNC_NEXT) begin
            cmd.ent.due = due_upd;
            if (empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                chosen_next = cell_entry[0].id;
                if (s_fire) begin
                    cmd.op = OP_NEXT;
                end
            end
        end else if (s_func == FUNC_CLEAR) begin
            if (s_fire) begin
                cmd.op     = OP_CLEAR;
                count_next = '0;
            end
        end
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        entry_t           l_entry, r_entry;
        logic [SEQ_W-1:0] l_seq, r_seq;
        logic             l_valid, l_less, r_less;

        if (i == 0) begin : g_first
            assign l_entry = '0;
            assign l_seq   = '0;
            assign l_valid = 1'b0;
            assign l_less  = 1'b1;
        end else begin : g_mid_l
            assign l_entry = cell_entry[i-1];
            assign l_seq   = cell_seq[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_less  = cell_less[i-1];
        end

        if (i == ENTRIES - 1) begin : g_last
            assign r_entry = '0;
            assign r_seq   = '0;
            assign r_less  = 1'b0;
        end else begin : g_mid_r
            assign r_entry = cell_entry[i+1];
            assign r_seq   = cell_seq[i+1];
            assign r_less  = cell_less[i+1];
        end

        pss_cell #(
            .SEQ_W(SEQ_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .head        ((i == 0) ? 1'b1 : 1'b0),
            .cmd         (cmd),
            .cmd_seq     (cmd_seq),
            .left_entry  (l_entry),
            .left_seq    (l_seq),
            .left_valid  (l_valid),
            .left_less   (l_less),
            .right_entry (r_entry),
            .right_seq   (r_seq),
            .right_less  (r_less),
            .entry_o     (cell_entry[i]),
            .seq_o       (cell_seq[i]),
            .valid_o     (cell_valid[i]),
            .less_o      (cell_less[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            status_reg <= status_next;
            chosen_reg <= chosen_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_chosen_id = chosen_reg;

endmodule
